// ----- hw/rtl/gnta_pkg.sv -----
package gnta_pkg;

   // Field widths of one blob beat and one track result
   localparam int THRESH_W      = 10;
   localparam int PX_W          = 10;
   localparam int PY_W          = 9;
   localparam int KX_W          = 10;
   localparam int KY_W          = 9;
   localparam int KZ_W          = 14;
   localparam int TRACK_INDEX_W = 2;

   // Squared distances: 10-bit and 9-bit deltas
   localparam int DX_SQ_W     = 2 * PX_W;
   localparam int DY_SQ_W     = 2 * PY_W;
   localparam int THRESH_SQ_W = 2 * THRESH_W;
   localparam int DIST_SQ_W   = DX_SQ_W + 1;

   localparam logic [THRESH_W-1:0]    THRESH_RESET    = 10'd40;
   localparam logic [THRESH_SQ_W-1:0] THRESH_SQ_RESET = 20'd1600;

   // Input beat kinds
   localparam logic MODE_BLOB = 1'b0;
   localparam logic MODE_EOF  = 1'b1;

   typedef struct packed {
      logic [PX_W-1:0] px;
      logic [PY_W-1:0] py;
      logic [KX_W-1:0] kx;
      logic [KY_W-1:0] ky;
      logic [KZ_W-1:0] kz;
   } blob_type;

   // Controller to datapath
   typedef struct packed {
      logic blob_wr;
      logic frame_start;
      logic scan_init;
      logic j_clr;
      logic j_inc;
      logic i_clr;
      logic i_inc;
      logic rd_best;
      logic square;
      logic compare;
      logic take_best;
      logic take_left;
      logic emit;
      logic frame_done;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic trk_ok;
      logic j_claimed;
      logic j_last;
      logic i_last;
      logic have;
      logic n_zero;
      logic free_any;
      logic out_free;
   } dp_status_type;

endpackage

// ----- hw/rtl/gnta_ctrl.sv -----
module gnta_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_mode,
   output logic                    req_stall,
   input  gnta_pkg::dp_status_type sts,
   output gnta_pkg::dp_cmd_type    cmd
);
   import gnta_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_TRK   = 4'd1;
   localparam logic [3:0] ST_RD    = 4'd2;
   localparam logic [3:0] ST_SQ    = 4'd3;
   localparam logic [3:0] ST_CMP   = 4'd4;
   localparam logic [3:0] ST_TEND  = 4'd5;
   localparam logic [3:0] ST_TTAKE = 4'd6;
   localparam logic [3:0] ST_TNEXT = 4'd7;
   localparam logic [3:0] ST_LCHK  = 4'd8;
   localparam logic [3:0] ST_LTAKE = 4'd9;
   localparam logic [3:0] ST_EMIT  = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // Take beats only while idle
   assign req_stall = (state_ff != ST_IDLE);

   // Sequence the matching pass, the leftover pass and the result walk
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_BLOB) begin
                  cmd.blob_wr = 1'b1;
               end else begin
                  cmd.frame_start = 1'b1;
                  state_in        = ST_TRK;
               end
            end
         end
         ST_TRK: begin
            if (sts.trk_ok) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_RD;
            end else begin
               state_in = ST_TNEXT;
            end
         end
         ST_RD: begin
            if (sts.j_claimed) begin
               if (sts.j_last) begin
                  state_in = ST_TEND;
               end else begin
                  cmd.j_inc = 1'b1;
               end
            end else begin
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.square = 1'b1;
            state_in   = ST_CMP;
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
            if (sts.j_last) begin
               state_in = ST_TEND;
            end else begin
               cmd.j_inc = 1'b1;
               state_in  = ST_RD;
            end
         end
         ST_TEND: begin
            if (sts.have) begin
               cmd.rd_best = 1'b1;
               state_in    = ST_TTAKE;
            end else begin
               state_in = ST_TNEXT;
            end
         end
         ST_TTAKE: begin
            cmd.take_best = 1'b1;
            state_in      = ST_TNEXT;
         end
         ST_TNEXT: begin
            if (sts.i_last) begin
               cmd.j_clr = 1'b1;
               if (sts.n_zero) begin
                  cmd.i_clr = 1'b1;
                  state_in  = ST_EMIT;
               end else begin
                  state_in = ST_LCHK;
               end
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = ST_TRK;
            end
         end
         ST_LCHK: begin
            if (sts.j_claimed || !sts.free_any) begin
               if (sts.j_last) begin
                  cmd.i_clr = 1'b1;
                  state_in  = ST_EMIT;
               end else begin
                  cmd.j_inc = 1'b1;
               end
            end else begin
               state_in = ST_LTAKE;
            end
         end
         ST_LTAKE: begin
            cmd.take_left = 1'b1;
            if (sts.j_last) begin
               cmd.i_clr = 1'b1;
               state_in  = ST_EMIT;
            end else begin
               cmd.j_inc = 1'b1;
               state_in  = ST_LCHK;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.i_last) begin
                  cmd.frame_done = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.i_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/gnta_dpath.sv -----
module gnta_dpath #(
   parameter int NUM_TRACKS = 4,
   parameter int MAX_BLOBS  = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  gnta_pkg::dp_cmd_type                   cmd,
   output gnta_pkg::dp_status_type                sts,
   input  logic [gnta_pkg::PX_W-1:0]              req_probe_x,
   input  logic [gnta_pkg::PY_W-1:0]              req_probe_y,
   input  logic [gnta_pkg::KX_W-1:0]              req_key_x,
   input  logic [gnta_pkg::KY_W-1:0]              req_key_y,
   input  logic [gnta_pkg::KZ_W-1:0]              req_key_z,
   input  logic                                   csr_wr_en,
   input  logic [gnta_pkg::THRESH_W-1:0]          csr_wr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [gnta_pkg::TRACK_INDEX_W-1:0]     rsp_track_index,
   output logic                                   rsp_found,
   output logic [gnta_pkg::KX_W-1:0]              rsp_out_x,
   output logic [gnta_pkg::KY_W-1:0]              rsp_out_y,
   output logic [gnta_pkg::KZ_W-1:0]              rsp_out_z,
   output logic                                   rsp_overflow,
   output logic                                   rsp_last
);
   import gnta_pkg::*;

   localparam int CNT_W  = $clog2(MAX_BLOBS + 1);
   localparam int BIDX_W = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
   localparam int TIDX_W = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;

   // Blob store, written in load order, read one entry a cycle
   blob_type blob_mem [MAX_BLOBS];
   blob_type rd_data_ff;
   logic [BIDX_W-1:0] rd_addr;

   logic [CNT_W-1:0]  blob_count_ff, blob_count_in;
   logic              overflow_ff, overflow_in;
   logic [THRESH_SQ_W-1:0] thresh_sq_ff;

   logic [CNT_W-1:0]  j_ff, j_in;
   logic [TIDX_W-1:0] i_ff, i_in;
   logic [BIDX_W-1:0] j_idx;

   logic [MAX_BLOBS-1:0]  claimed_ff, claimed_in;
   logic [NUM_TRACKS-1:0] found_ff, found_in;
   logic [NUM_TRACKS-1:0] track_valid_ff, track_valid_in;
   logic [KX_W-1:0] track_x_ff [NUM_TRACKS];
   logic [KX_W-1:0] track_x_in [NUM_TRACKS];
   logic [KY_W-1:0] track_y_ff [NUM_TRACKS];
   logic [KY_W-1:0] track_y_in [NUM_TRACKS];
   logic [KZ_W-1:0] track_z_ff [NUM_TRACKS];
   logic [KZ_W-1:0] track_z_in [NUM_TRACKS];

   logic                 have_ff, have_in;
   logic [DIST_SQ_W-1:0] best_ff, best_in;
   logic [BIDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [DX_SQ_W-1:0]   dx_sq_ff;
   logic [DY_SQ_W-1:0]   dy_sq_ff;
   logic [PX_W-1:0]      dx;
   logic [PY_W-1:0]      dy;
   logic [DIST_SQ_W-1:0] dist_sq;
   logic                 near;

   logic [TIDX_W-1:0] free_idx;
   logic              free_any;
   logic              blob_room;
   logic              out_free;
   logic              found_cur;
   logic              rsp_valid_ff;

   assign j_idx     = j_ff[BIDX_W-1:0];
   assign blob_room = (blob_count_ff < CNT_W'(MAX_BLOBS));
   assign rd_addr   = cmd.rd_best ? best_idx_ff : j_idx;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign found_cur = found_ff[i_ff];

   // Store blob beats and read the addressed entry
   always_ff @(posedge clock) begin
      if (cmd.blob_wr && blob_room) begin
         blob_mem[blob_count_ff[BIDX_W-1:0]] <= '{px: req_probe_x, py: req_probe_y,
                                                 kx: req_key_x, ky: req_key_y,
                                                 kz: req_key_z};
      end
      rd_data_ff <= blob_mem[rd_addr];
   end

   // Lowest track that has found nothing yet
   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int t = NUM_TRACKS - 1; t >= 0; t--) begin
         if (!found_ff[t]) begin
            free_any = 1'b1;
            free_idx = TIDX_W'(t);
         end
      end
   end

   // Distance from the current track to the blob just read
   always_comb begin
      dx = (track_x_ff[i_ff] >= rd_data_ff.px) ? track_x_ff[i_ff] - rd_data_ff.px
                                               : rd_data_ff.px - track_x_ff[i_ff];
      dy = (track_y_ff[i_ff] >= rd_data_ff.py) ? track_y_ff[i_ff] - rd_data_ff.py
                                               : rd_data_ff.py - track_y_ff[i_ff];
   end

   assign dist_sq = DIST_SQ_W'(dx_sq_ff) + DIST_SQ_W'(dy_sq_ff);
   assign near    = (dist_sq < DIST_SQ_W'(thresh_sq_ff));

   // Square the deltas into registers
   always_ff @(posedge clock) begin
      if (cmd.square) begin
         dx_sq_ff <= DX_SQ_W'(dx * dx);
         dy_sq_ff <= DY_SQ_W'(dy * dy);
      end
   end

   // Counters and best-candidate tracking
   always_comb begin
      j_in        = j_ff;
      i_in        = i_ff;
      have_in     = have_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (cmd.scan_init || cmd.j_clr) begin
         j_in = '0;
      end else if (cmd.j_inc) begin
         j_in = CNT_W'(j_ff + CNT_W'(1));
      end
      if (cmd.frame_start || cmd.i_clr) begin
         i_in = '0;
      end else if (cmd.i_inc) begin
         i_in = TIDX_W'(i_ff + TIDX_W'(1));
      end
      if (cmd.scan_init) begin
         have_in = 1'b0;
      end else if (cmd.compare && near && (!have_ff || dist_sq < best_ff)) begin
         have_in     = 1'b1;
         best_in     = dist_sq;
         best_idx_in = j_idx;
      end
   end

   // Frame fill state and track table
   always_comb begin
      blob_count_in  = blob_count_ff;
      overflow_in    = overflow_ff;
      claimed_in     = claimed_ff;
      found_in       = found_ff;
      track_valid_in = track_valid_ff;
      track_x_in     = track_x_ff;
      track_y_in     = track_y_ff;
      track_z_in     = track_z_ff;
      if (cmd.blob_wr) begin
         if (blob_room) begin
            blob_count_in = CNT_W'(blob_count_ff + CNT_W'(1));
         end else begin
            overflow_in = 1'b1;
         end
      end
      if (cmd.frame_start) begin
         claimed_in = '0;
         found_in   = '0;
      end
      if (cmd.take_best) begin
         claimed_in[best_idx_ff] = 1'b1;
         found_in[i_ff]          = 1'b1;
         track_x_in[i_ff]        = rd_data_ff.kx;
         track_y_in[i_ff]        = rd_data_ff.ky;
         track_z_in[i_ff]        = rd_data_ff.kz;
      end
      if (cmd.take_left) begin
         found_in[free_idx]   = 1'b1;
         track_x_in[free_idx] = rd_data_ff.kx;
         track_y_in[free_idx] = rd_data_ff.ky;
         track_z_in[free_idx] = rd_data_ff.kz;
      end
      if (cmd.emit) begin
         track_valid_in[i_ff] = found_cur;
         if (!found_cur) begin
            track_x_in[i_ff] = '0;
            track_y_in[i_ff] = '0;
            track_z_in[i_ff] = '0;
         end
      end
      if (cmd.frame_done) begin
         blob_count_in = '0;
         overflow_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blob_count_ff  <= '0;
         overflow_ff    <= 1'b0;
         thresh_sq_ff   <= THRESH_SQ_RESET;
         j_ff           <= '0;
         i_ff           <= '0;
         have_ff        <= 1'b0;
         claimed_ff     <= '0;
         found_ff       <= '0;
         track_valid_ff <= '0;
         for (int t = 0; t < NUM_TRACKS; t++) begin
            track_x_ff[t] <= '0;
            track_y_ff[t] <= '0;
            track_z_ff[t] <= '0;
         end
      end else begin
         blob_count_ff  <= blob_count_in;
         overflow_ff    <= overflow_in;
         if (csr_wr_en) begin
            thresh_sq_ff <= THRESH_SQ_W'(csr_wr_data * csr_wr_data);
         end
         j_ff           <= j_in;
         i_ff           <= i_in;
         have_ff        <= have_in;
         claimed_ff     <= claimed_in;
         found_ff       <= found_in;
         track_valid_ff <= track_valid_in;
         track_x_ff     <= track_x_in;
         track_y_ff     <= track_y_in;
         track_z_ff     <= track_z_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   // Result register: load a beat when free, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_track_index <= TRACK_INDEX_W'(i_ff);
         rsp_found       <= found_cur;
         rsp_out_x       <= found_cur ? track_x_ff[i_ff] : '0;
         rsp_out_y       <= found_cur ? track_y_ff[i_ff] : '0;
         rsp_out_z       <= found_cur ? track_z_ff[i_ff] : '0;
         rsp_overflow    <= overflow_ff;
         rsp_last        <= sts.i_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Status back to the controller
   always_comb begin
      sts           = '0;
      sts.n_zero    = (blob_count_ff == '0);
      sts.trk_ok    = track_valid_ff[i_ff] && !sts.n_zero;
      sts.j_claimed = claimed_ff[j_idx];
      sts.j_last    = (j_ff == CNT_W'(blob_count_ff - CNT_W'(1)));
      sts.i_last    = (i_ff == TIDX_W'(NUM_TRACKS - 1));
      sts.have      = have_ff;
      sts.free_any  = free_any;
      sts.out_free  = out_free;
   end

endmodule

// ----- hw/rtl/greedy_nearest_track_assign_top.sv -----
// Greedy nearest-neighbor track association.
// Input channel (req_*): one beat per blob with req_mode low, carrying the probe
// point used for the distance test and the key point stored into a track. A beat
// with req_mode high closes the frame and starts the assignment. Blobs beyond
// MAX_BLOBS are dropped and flagged in rsp_overflow.
// Result channel (rsp_*): NUM_TRACKS beats per frame, track 0 first, rsp_last on
// the final one. No beat follows a blob beat.
// Configuration: csr_wr_en with csr_wr_data writes the distance limit (reset 40);
// the limit is squared once at the write.
// Sequencing: a blob beat leaves the controller idle, so req_stall stays low for
// the next beat. An end-of-frame beat starts the controller walking tracks times
// blobs through one shared distance unit (read, square, compare for each blob)
// and one store read port.
// req_stall is high for that whole walk; it is low again once the last result
// is loaded into the output register, even if that result is still stalled.
// A stalled result holds; the walk pauses at the next result until it is taken.
// Reset: all tracks invalid and zeroed, blob store empty, no results pending.
module greedy_nearest_track_assign_top #(
   parameter int NUM_TRACKS = 4,
   parameter int MAX_BLOBS  = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic [gnta_pkg::PX_W-1:0]          req_probe_x,
   input  logic [gnta_pkg::PY_W-1:0]          req_probe_y,
   input  logic [gnta_pkg::KX_W-1:0]          req_key_x,
   input  logic [gnta_pkg::KY_W-1:0]          req_key_y,
   input  logic [gnta_pkg::KZ_W-1:0]          req_key_z,
   input  logic                               csr_wr_en,
   input  logic [gnta_pkg::THRESH_W-1:0]      csr_wr_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [gnta_pkg::TRACK_INDEX_W-1:0] rsp_track_index,
   output logic                               rsp_found,
   output logic [gnta_pkg::KX_W-1:0]          rsp_out_x,
   output logic [gnta_pkg::KY_W-1:0]          rsp_out_y,
   output logic [gnta_pkg::KZ_W-1:0]          rsp_out_z,
   output logic                               rsp_overflow,
   output logic                               rsp_last
);
   import gnta_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;

   gnta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gnta_dpath #(
      .NUM_TRACKS (NUM_TRACKS),
      .MAX_BLOBS  (MAX_BLOBS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_probe_x     (req_probe_x),
      .req_probe_y     (req_probe_y),
      .req_key_x       (req_key_x),
      .req_key_y       (req_key_y),
      .req_key_z       (req_key_z),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_track_index (rsp_track_index),
      .rsp_found       (rsp_found),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_overflow    (rsp_overflow),
      .rsp_last        (rsp_last)
   );

endmodule

// ----- tb/track_assign_checker.sv -----
module track_assign_checker #(
   parameter int NUM_TRACKS = 4,
   parameter int MAX_BLOBS  = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               req_mode,
   input  logic [gnta_pkg::PX_W-1:0]          req_probe_x,
   input  logic [gnta_pkg::PY_W-1:0]          req_probe_y,
   input  logic [gnta_pkg::KX_W-1:0]          req_key_x,
   input  logic [gnta_pkg::KY_W-1:0]          req_key_y,
   input  logic [gnta_pkg::KZ_W-1:0]          req_key_z,
   input  logic                               csr_wr_en,
   input  logic [gnta_pkg::THRESH_W-1:0]      csr_wr_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [gnta_pkg::TRACK_INDEX_W-1:0] rsp_track_index,
   input  logic                               rsp_found,
   input  logic [gnta_pkg::KX_W-1:0]          rsp_out_x,
   input  logic [gnta_pkg::KY_W-1:0]          rsp_out_y,
   input  logic [gnta_pkg::KZ_W-1:0]          rsp_out_z,
   input  logic                               rsp_overflow,
   input  logic                               rsp_last,
   output int                                 fail_count,
   output int                                 reports_due
);
   timeunit 1ns;
   timeprecision 1ps;
   import gnta_pkg::*;

   typedef struct {
      logic [TRACK_INDEX_W-1:0] index;
      logic                     found;
      logic [KX_W-1:0]          x;
      logic [KY_W-1:0]          y;
      logic [KZ_W-1:0]          z;
      logic                     overflow;
      logic                     last;
   } track_report_type;

   // Expected track reports, oldest first
   track_report_type track_reports[$];

   // Shadow of the block state
   logic [THRESH_W-1:0] dist_limit;
   logic                trk_valid [NUM_TRACKS];
   logic [KX_W-1:0]     trk_x [NUM_TRACKS];
   logic [KY_W-1:0]     trk_y [NUM_TRACKS];
   logic [KZ_W-1:0]     trk_z [NUM_TRACKS];
   blob_type            frame_blobs [MAX_BLOBS];
   int                  blob_total;
   logic                blobs_dropped;
   int                  errs = 0;

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned seen);
      if (want != seen) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
         errs++;
      end
   endtask

   task automatic blob_dropped_clear();
      blobs_dropped = 1'b0;
   endtask

   // Greedy association for one frame; queue one report per track
   task automatic associate_frame();
      logic             claimed [MAX_BLOBS];
      logic             got [NUM_TRACKS];
      logic [31:0]      lim_sq, best, d2, dx, dy, ta, pa;
      logic             have, placed;
      int               bi;
      track_report_type rep;

      lim_sq = 32'(dist_limit) * 32'(dist_limit);
      for (int j = 0; j < MAX_BLOBS; j++) claimed[j] = 1'b0;
      for (int i = 0; i < NUM_TRACKS; i++) got[i] = 1'b0;

      // Nearest unclaimed blob below the limit, tracks in index order
      for (int i = 0; i < NUM_TRACKS; i++) begin
         if (trk_valid[i]) begin
            have = 1'b0;
            best = 0;
            bi   = 0;
            for (int j = 0; j < blob_total; j++) begin
               if (!claimed[j]) begin
                  ta = 32'(trk_x[i]);
                  pa = 32'(frame_blobs[j].px);
                  dx = (ta >= pa) ? ta - pa : pa - ta;
                  ta = 32'(trk_y[i]);
                  pa = 32'(frame_blobs[j].py);
                  dy = (ta >= pa) ? ta - pa : pa - ta;
                  d2 = dx * dx + dy * dy;
                  if (d2 < lim_sq && (!have || d2 < best)) begin
                     have = 1'b1;
                     best = d2;
                     bi   = j;
                  end
               end
            end
            if (have) begin
               claimed[bi] = 1'b1;
               trk_x[i] = frame_blobs[bi].kx;
               trk_y[i] = frame_blobs[bi].ky;
               trk_z[i] = frame_blobs[bi].kz;
               got[i]   = 1'b1;
            end
         end
      end

      // Hand leftover blobs to the first tracks still empty
      for (int j = 0; j < blob_total; j++) begin
         if (!claimed[j]) begin
            placed = 1'b0;
            for (int i = 0; i < NUM_TRACKS; i++) begin
               if (!placed && !got[i]) begin
                  trk_x[i] = frame_blobs[j].kx;
                  trk_y[i] = frame_blobs[j].ky;
                  trk_z[i] = frame_blobs[j].kz;
                  got[i]   = 1'b1;
                  placed   = 1'b1;
               end
            end
         end
      end

      // Drop empty tracks and queue the reports
      for (int i = 0; i < NUM_TRACKS; i++) begin
         trk_valid[i] = got[i];
         if (!got[i]) begin
            trk_x[i] = '0;
            trk_y[i] = '0;
            trk_z[i] = '0;
         end
         rep.index    = i[TRACK_INDEX_W-1:0];
         rep.found    = got[i];
         rep.x        = trk_x[i];
         rep.y        = trk_y[i];
         rep.z        = trk_z[i];
         rep.overflow = blobs_dropped;
         rep.last     = (i == NUM_TRACKS - 1);
         track_reports.insert(track_reports.size(), rep);
      end

      blob_total    = 0;
      blob_dropped_clear();
   endtask

   // Sample both channels and the register port at each edge
   always @(posedge clock) begin : watch
      track_report_type rep;
      if (reset) begin
         dist_limit    = THRESH_RESET;
         blob_total    = 0;
         blobs_dropped = 1'b0;
         for (int i = 0; i < NUM_TRACKS; i++) begin
            trk_valid[i] = 1'b0;
            trk_x[i]     = '0;
            trk_y[i]     = '0;
            trk_z[i]     = '0;
         end
         track_reports.delete();
      end else begin
         // Compare a result beat with the oldest report
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (track_reports.size() == 0) begin
               $display("%0t: result beat for track %0d with none expected",
                        $time, rsp_track_index);
               errs++;
            end else begin
               rep = track_reports[0];
               track_reports.delete(0);
               check_field("track_index", 32'(rep.index), 32'(rsp_track_index));
               check_field("found", 32'(rep.found), 32'(rsp_found));
               check_field("out_x", 32'(rep.x), 32'(rsp_out_x));
               check_field("out_y", 32'(rep.y), 32'(rsp_out_y));
               check_field("out_z", 32'(rep.z), 32'(rsp_out_z));
               check_field("overflow", 32'(rep.overflow), 32'(rsp_overflow));
               check_field("last", 32'(rep.last), 32'(rsp_last));
            end
         end
         if (csr_wr_en === 1'b1)
            dist_limit = csr_wr_data;
         // Store a blob beat or close the frame
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            if (req_mode == MODE_BLOB) begin
               if (blob_total < MAX_BLOBS) begin
                  frame_blobs[blob_total].px = req_probe_x;
                  frame_blobs[blob_total].py = req_probe_y;
                  frame_blobs[blob_total].kx = req_key_x;
                  frame_blobs[blob_total].ky = req_key_y;
                  frame_blobs[blob_total].kz = req_key_z;
                  blob_total++;
               end else begin
                  blobs_dropped = 1'b1;
               end
            end else begin
               associate_frame();
            end
         end
      end
      fail_count  <= errs;
      reports_due <= track_reports.size();
   end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gnta_pkg::*;

   localparam int NUM_TRACKS   = 4;
   localparam int MAX_BLOBS    = 8;
   localparam int DRAIN_CYCLES = 200;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_mode = MODE_BLOB;
   logic [PX_W-1:0]          req_probe_x = '0;
   logic [PY_W-1:0]          req_probe_y = '0;
   logic [KX_W-1:0]          req_key_x = '0;
   logic [KY_W-1:0]          req_key_y = '0;
   logic [KZ_W-1:0]          req_key_z = '0;
   logic                     csr_wr_en = 1'b0;
   logic [THRESH_W-1:0]      csr_wr_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [TRACK_INDEX_W-1:0] rsp_track_index;
   logic                     rsp_found;
   logic [KX_W-1:0]          rsp_out_x;
   logic [KY_W-1:0]          rsp_out_y;
   logic [KZ_W-1:0]          rsp_out_z;
   logic                     rsp_overflow;
   logic                     rsp_last;
   int                       fail_count;
   int                       reports_due;

   logic idle_en = 1'b1;
   int   beats_sent = 0;
   int   cur_limit = int'(THRESH_RESET);
   int   near_x[$];
   int   near_y[$];

   greedy_nearest_track_assign_top #(
      .NUM_TRACKS(NUM_TRACKS),
      .MAX_BLOBS (MAX_BLOBS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_probe_x    (req_probe_x),
      .req_probe_y    (req_probe_y),
      .req_key_x      (req_key_x),
      .req_key_y      (req_key_y),
      .req_key_z      (req_key_z),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_track_index(rsp_track_index),
      .rsp_found      (rsp_found),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_overflow   (rsp_overflow),
      .rsp_last       (rsp_last)
   );

   track_assign_checker #(
      .NUM_TRACKS(NUM_TRACKS),
      .MAX_BLOBS (MAX_BLOBS)
   ) assign_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_probe_x    (req_probe_x),
      .req_probe_y    (req_probe_y),
      .req_key_x      (req_key_x),
      .req_key_y      (req_key_y),
      .req_key_z      (req_key_z),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_track_index(rsp_track_index),
      .rsp_found      (rsp_found),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_overflow   (rsp_overflow),
      .rsp_last       (rsp_last),
      .fail_count     (fail_count),
      .reports_due    (reports_due)
   );

   always #2 clock = ~clock;

   // Stall the result channel at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= idle_en && ($urandom_range(99) < 11);
      end
   end

   function automatic int clamp(input int v, input int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   // Drive one beat and hold it until accepted
   task automatic send_beat(input logic mode, input int px, input int py,
                            input int kx, input int ky, input int kz);
      if (idle_en && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_probe_x <= px[PX_W-1:0];
      req_probe_y <= py[PY_W-1:0];
      req_key_x   <= kx[KX_W-1:0];
      req_key_y   <= ky[KY_W-1:0];
      req_key_z   <= kz[KZ_W-1:0];
      do @(posedge clock); while (req_stall !== 1'b0);
      beats_sent++;
   endtask

   task automatic send_eof();
      send_beat(MODE_EOF, $urandom_range(1023), $urandom_range(511),
                $urandom_range(1023), $urandom_range(511), $urandom_range(16383));
   endtask

   // Wait for every expected report, then let the walk settle
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input int v);
      wait_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v[THRESH_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_limit = v;
   endtask

   // One frame: blobs mostly near last frame's key points, then end of frame
   task automatic random_frame();
      int n, r, span, px, py, kx, ky;
      int nx[$];
      int ny[$];
      r = $urandom_range(99);
      if (r < 8) n = 0;
      else if (r < 85) n = $urandom_range(1, 6);
      else if (r < 95) n = $urandom_range(7, MAX_BLOBS);
      else n = $urandom_range(MAX_BLOBS + 1, MAX_BLOBS + 3);
      span = (cur_limit < 60) ? cur_limit + 4 : 60;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (near_x.size() > 0 && r < 70) begin
            px = clamp(near_x[k % near_x.size()] + int'($urandom_range(2 * span)) - span,
                       1023);
            py = clamp(near_y[k % near_y.size()] + int'($urandom_range(2 * span)) - span,
                       511);
         end else if (r < 75) begin
            px = $urandom_range(1) * 1023;
            py = $urandom_range(1) * 511;
         end else begin
            px = $urandom_range(1023);
            py = $urandom_range(511);
         end
         kx = clamp(px + int'($urandom_range(6)) - 3, 1023);
         ky = clamp(py + int'($urandom_range(6)) - 3, 511);
         if (k < MAX_BLOBS) begin
            nx.insert(nx.size(), kx);
            ny.insert(ny.size(), ky);
         end
         send_beat(MODE_BLOB, px, py, kx, ky, $urandom_range(16383));
      end
      send_eof();
      near_x = nx;
      near_y = ny;
   endtask

   initial begin : stimulus
      int lim, phase_end;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty frame at the reset limit
      send_eof();
      // Two blobs, tracks all invalid: both go by the leftover pass
      send_beat(MODE_BLOB, 0, 0, 0, 0, 0);
      send_beat(MODE_BLOB, 1023, 511, 1023, 511, 16383);
      send_eof();
      // Tie for track 0, exact hit for track 1, boundary and surplus blobs
      send_beat(MODE_BLOB, 10, 0, 5, 5, 100);
      send_beat(MODE_BLOB, 0, 10, 6, 6, 200);
      send_beat(MODE_BLOB, 1023, 511, 1000, 500, 300);
      send_beat(MODE_BLOB, 39, 0, 7, 7, 400);
      send_beat(MODE_BLOB, 40, 0, 8, 8, 500);
      send_eof();
      // Overflow: one blob past capacity
      for (int k = 0; k <= MAX_BLOBS; k++)
         send_beat(MODE_BLOB, 1023 - k, 511 - k, 1023 - 2 * k, 511 - 2 * k, 16383 - k);
      send_eof();
      // Zero limit: leftover pass only
      write_limit(0);
      send_beat(MODE_BLOB, 1023, 511, 1, 2, 3);
      send_beat(MODE_BLOB, 1022, 510, 4, 5, 6);
      send_eof();
      // Widest limit
      write_limit(1023);
      send_beat(MODE_BLOB, 0, 0, 512, 256, 8191);
      send_beat(MODE_BLOB, 1023, 511, 511, 255, 8192);
      send_eof();

      // Random frames across several limits, one phase without idling
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: lim = 1023;
            1: lim = 0;
            2: lim = 40;
            3: lim = 1;
            default: lim = $urandom_range(2, ($urandom_range(3) == 0) ? 1023 : 120);
         endcase
         write_limit(lim);
         idle_en = (ph != 2);
         phase_end = beats_sent + 35;
         while (beats_sent < phase_end) random_frame();
      end

      idle_en = 1'b1;
      wait_drain();
      if (fail_count == 0 && reports_due == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Give up on a hung run
   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
